// File: rtl/core/tire_magic_formula_force_macros.svh
// ----------------------------------------------------------------------------
// tire_magic_formula_force_macros
// assertion shorthands used by the tire force top module
// ----------------------------------------------------------------------------
`ifndef TIRE_MAGIC_FORMULA_FORCE_MACROS_SVH
`define TIRE_MAGIC_FORMULA_FORCE_MACROS_SVH

// checked only outside reset
`define TMFF_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define TMFF_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: rtl/core/tmff_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmff_pkg
// constants, formats and tables of the magic formula tire force pipeline
// ----------------------------------------------------------------------------
package tmff_pkg;

  localparam int unsigned CordicStagesDef = 16;
  localparam int unsigned AtanTabLen      = 24;

  // wide datapath for the arctangent passes, narrow one for the sine pass
  localparam int unsigned CordicW = 52;
  localparam int unsigned SinW    = 36;

  localparam logic [31:0] AtanTab [AtanTabLen] = '{
    32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
    32'd33543516, 32'd16775851, 32'd8388437, 32'd4194283, 32'd2097149,
    32'd1048576, 32'd524288, 32'd262144, 32'd131072, 32'd65536, 32'd32768,
    32'd16384, 32'd8192, 32'd4096, 32'd2048, 32'd1024, 32'd512, 32'd256,
    32'd128
  };

  localparam logic [31:0] OneQ30  = 32'd1073741824;
  localparam logic [31:0] GainQ30 = 32'd652032874;

  localparam logic [36:0] PiQ30     = 37'd3373259426;
  localparam logic [36:0] HalfPiQ30 = 37'd1686629713;
  localparam logic [36:0] TwoPiQ30  = 37'd6746518852;
  // offset that makes every reachable sine argument positive
  localparam logic [39:0] TwoPi5Q30 = 40'd33732594260;

  typedef enum logic [1:0] {
    RegStiffness = 2'd0,
    RegShape     = 2'd1,
    RegPeak      = 2'd2,
    RegCurvature = 2'd3
  } cfg_reg_e;

  localparam logic [15:0] StiffnessRst = 16'd2560;
  localparam logic [15:0] ShapeRst     = 16'd7782;
  localparam logic [15:0] PeakRst      = 16'd4000;
  localparam logic [15:0] CurvatureRst = 16'd3973;

endpackage

// File: rtl/core/tmff_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmff_if
// valid/ready channels carrying slip beats in and force beats out
// ----------------------------------------------------------------------------
interface tmff_slip_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] slip_value;

  modport source (output valid, output slip_value, input ready);
  modport sink   (input valid, input slip_value, output ready);
endinterface

interface tmff_force_if;
  logic               valid;
  logic               ready;
  logic signed [16:0] tire_force;

  modport source (output valid, output tire_force, input ready);
  modport sink   (input valid, input tire_force, output ready);
endinterface

// File: rtl/core/tmff_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmff_cordic
// unrolled cordic, one register stage per iteration, vectoring or rotation
// ----------------------------------------------------------------------------
module tmff_cordic #(
  parameter int unsigned STAGES    = 16,
  parameter int unsigned W         = 52,
  parameter int unsigned PW        = 1,
  parameter bit          VECTORING = 1'b1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                vld_i,
  input  logic signed [W-1:0] x_i,
  input  logic signed [W-1:0] y_i,
  input  logic signed [W-1:0] z_i,
  input  logic [PW-1:0]       pl_i,
  output logic                vld_o,
  output logic signed [W-1:0] y_o,
  output logic signed [W-1:0] z_o,
  output logic [PW-1:0]       pl_o
);
  import tmff_pkg::*;

  logic signed [W-1:0] x_s [STAGES+1];
  logic signed [W-1:0] y_s [STAGES+1];
  logic signed [W-1:0] z_s [STAGES+1];
  logic [PW-1:0]       pl_s [STAGES+1];
  logic                vld_s [STAGES+1];

  assign x_s[0]   = x_i;
  assign y_s[0]   = y_i;
  assign z_s[0]   = z_i;
  assign pl_s[0]  = pl_i;
  assign vld_s[0] = vld_i;

  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    logic signed [W-1:0] xs, ys, ang, x_d, y_d, z_d;
    logic                pos;

    always_comb begin
      xs  = x_s[k] >>> k;
      ys  = y_s[k] >>> k;
      ang = $signed({{(W-32){1'b0}}, AtanTab[k]});
      pos = VECTORING ? !y_s[k][W-1] : !z_s[k][W-1];
      if (VECTORING == pos) begin
        // vectoring with y >= 0, or rotation with z < 0
        x_d = x_s[k] + ys;
        y_d = y_s[k] - xs;
      end else begin
        x_d = x_s[k] - ys;
        y_d = y_s[k] + xs;
      end
      if (VECTORING == pos) begin
        z_d = z_s[k] + ang;
      end else begin
        z_d = z_s[k] - ang;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_s[k+1] <= 1'b0;
      end else if (en_i) begin
        vld_s[k+1] <= vld_s[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_s[k+1]  <= x_d;
        y_s[k+1]  <= y_d;
        z_s[k+1]  <= z_d;
        pl_s[k+1] <= pl_s[k];
      end
    end
  end

  assign vld_o = vld_s[STAGES];
  assign y_o   = y_s[STAGES];
  assign z_o   = z_s[STAGES];
  assign pl_o  = pl_s[STAGES];

endmodule

// File: rtl/core/tire_magic_formula_force.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tire_magic_formula_force
// pacejka magic formula tire force, fully pipelined fixed point datapath
// ----------------------------------------------------------------------------
// usage
//   slip_if_i carries one signed q4.12 slip value per beat, force_if_o one
//   saturated 17-bit force in newtons per beat, in the same order
//   b, c, d, e are written through cfg_we_i / cfg_idx_i / cfg_data_i while
//   no beat is in flight
//   a beat enters every cycle unless a finished force is stalled; the
//   path runs through the two arctangent passes and the sine pass of
//   unrolled cordic stages plus the multiply and range reduction stages
//   when the receiver stalls a finished force, the whole pipeline holds
//   and slip_if_i.ready drops in the same cycle; nothing is lost or doubled
//   reset empties the pipeline and loads the default coefficients
// ----------------------------------------------------------------------------
`include "tire_magic_formula_force_macros.svh"

module tire_magic_formula_force #(
  parameter int unsigned CORDIC_STAGES = tmff_pkg::CordicStagesDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [15:0]  cfg_data_i,
  tmff_slip_if.sink    slip_if_i,
  tmff_force_if.source force_if_o
);
  import tmff_pkg::*;

  localparam int unsigned CW = CordicW;
  localparam int unsigned SW = SinW;

  // coefficient registers
  logic [15:0]        stiff_q, shape_q, peak_q;
  logic signed [15:0] curv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stiff_q <= StiffnessRst;
      shape_q <= ShapeRst;
      peak_q  <= PeakRst;
      curv_q  <= CurvatureRst;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        RegStiffness: stiff_q <= cfg_data_i;
        RegShape:     shape_q <= cfg_data_i;
        RegPeak:      peak_q  <= cfg_data_i;
        RegCurvature: curv_q  <= cfg_data_i;
        default:      ;
      endcase
    end
  end

  // global advance: the pipeline moves unless a finished beat is stalled
  logic en;
  logic out_vld_q;
  assign en              = !out_vld_q || force_if_o.ready;
  assign slip_if_i.ready = en;

  // stage 1: bx = b * slip, q.20 scaled up to q.30
  logic signed [32:0]   bprod;
  logic signed [CW-1:0] bx_q;
  logic                 vld1_q;
  assign bprod = $signed({1'b0, stiff_q}) * slip_if_i.slip_value;

  // cordic a: atan(bx), bx travels along
  logic                 vld_a;
  logic signed [CW-1:0] a1, bx_a;
  logic [CW-1:0]        bx_a_pl;

  tmff_cordic #(
    .STAGES(CORDIC_STAGES), .W(CW), .PW(CW), .VECTORING(1'b1)
  ) u_atan_a (
    .clk_i, .rst_ni, .en_i(en), .vld_i(vld1_q),
    .x_i($signed({{(CW-32){1'b0}}, OneQ30})), .y_i(bx_q), .z_i('0),
    .pl_i(bx_q), .vld_o(vld_a), .y_o(), .z_o(a1), .pl_o(bx_a_pl)
  );
  assign bx_a = $signed(bx_a_pl);

  // stage 2: e * (bx - atan(bx))
  logic signed [CW-1:0] diff;
  logic signed [67:0]   eprod;
  logic signed [59:0]   ep_q;
  logic signed [CW-1:0] bx2_q;
  logic                 vld2_q;
  assign diff  = bx_a - a1;
  assign eprod = curv_q * diff;

  // stage 3: term = bx - round(e * (bx - atan(bx)))
  logic signed [59:0]   ep_rnd;
  logic signed [CW-1:0] term_q;
  logic                 vld3_q;
  assign ep_rnd = ep_q + 60'sd2048;

  // cordic b: atan(term)
  logic                 vld_b;
  logic signed [CW-1:0] a2;

  tmff_cordic #(
    .STAGES(CORDIC_STAGES), .W(CW), .PW(1), .VECTORING(1'b1)
  ) u_atan_b (
    .clk_i, .rst_ni, .en_i(en), .vld_i(vld3_q),
    .x_i($signed({{(CW-32){1'b0}}, OneQ30})), .y_i(term_q), .z_i('0),
    .pl_i(1'b0), .vld_o(vld_b), .y_o(), .z_o(a2), .pl_o()
  );

  // stage 4: c * atan(term)
  logic signed [50:0] cp_q;
  logic               vld4_q;

  // stage 5: round to theta and shift into the positive range
  logic signed [50:0] cp_rnd;
  logic signed [39:0] theta_ext;
  logic signed [39:0] t_sum;
  logic [36:0]        t_q;
  logic               vld5_q;
  assign cp_rnd    = cp_q + 51'sd2048;
  assign theta_ext = {cp_rnd[50], cp_rnd[50:12]};
  assign t_sum     = theta_ext + $signed(TwoPi5Q30);

  // stage 6: reduce modulo two pi by conditional subtraction
  logic [36:0] m8, m4, m2, m1;
  logic [32:0] r_q;
  logic        vld6_q;
  always_comb begin
    m8 = (t_q >= (TwoPiQ30 << 3)) ? t_q - (TwoPiQ30 << 3) : t_q;
    m4 = (m8 >= (TwoPiQ30 << 2)) ? m8 - (TwoPiQ30 << 2) : m8;
    m2 = (m4 >= (TwoPiQ30 << 1)) ? m4 - (TwoPiQ30 << 1) : m4;
    m1 = (m2 >= TwoPiQ30) ? m2 - TwoPiQ30 : m2;
  end

  // stage 7: fold into [-pi/2, pi/2]
  logic signed [SW-1:0] rs, fold, z0_q;
  logic                 vld7_q;
  localparam logic signed [SW-1:0] PiS     = $signed(PiQ30[SW-1:0]);
  localparam logic signed [SW-1:0] HalfPiS = $signed(HalfPiQ30[SW-1:0]);
  localparam logic signed [SW-1:0] TwoPiS  = $signed(TwoPiQ30[SW-1:0]);
  always_comb begin
    rs = $signed({{(SW-33){1'b0}}, r_q});
    if (rs >= PiS) begin
      rs = rs - TwoPiS;
    end
    priority if (rs > HalfPiS) begin
      fold = PiS - rs;
    end else if (rs < -HalfPiS) begin
      fold = -PiS - rs;
    end else begin
      fold = rs;
    end
  end

  // cordic c: sine by rotation from the pre-scaled gain
  logic                 vld_c;
  logic signed [SW-1:0] sin_y;

  tmff_cordic #(
    .STAGES(CORDIC_STAGES), .W(SW), .PW(1), .VECTORING(1'b0)
  ) u_sin (
    .clk_i, .rst_ni, .en_i(en), .vld_i(vld7_q),
    .x_i($signed({{(SW-32){1'b0}}, GainQ30})), .y_i('0), .z_i(z0_q),
    .pl_i(1'b0), .vld_o(vld_c), .y_o(sin_y), .z_o(), .pl_o()
  );

  // stage 8: d * sin
  logic signed [52:0] dp_q;
  logic               vld8_q;

  // stage 9: round to newtons and saturate into the output register
  logic signed [52:0] dp_rnd;
  logic signed [22:0] f_full;
  logic signed [16:0] f_sat;
  logic signed [16:0] force_q;
  assign dp_rnd = dp_q + 53'sd536870912;
  assign f_full = dp_rnd[52:30];
  always_comb begin
    priority if (f_full > 23'sd65535) begin
      f_sat = 17'sd65535;
    end else if (f_full < -23'sd65536) begin
      f_sat = -17'sd65536;
    end else begin
      f_sat = f_full[16:0];
    end
  end

  // valid bits of the plain stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q    <= 1'b0;
      vld2_q    <= 1'b0;
      vld3_q    <= 1'b0;
      vld4_q    <= 1'b0;
      vld5_q    <= 1'b0;
      vld6_q    <= 1'b0;
      vld7_q    <= 1'b0;
      vld8_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld1_q    <= slip_if_i.valid;
      vld2_q    <= vld_a;
      vld3_q    <= vld2_q;
      vld4_q    <= vld_b;
      vld5_q    <= vld4_q;
      vld6_q    <= vld5_q;
      vld7_q    <= vld6_q;
      vld8_q    <= vld_c;
      out_vld_q <= vld8_q;
    end
  end

  // payload of the plain stages
  always_ff @(posedge clk_i) begin
    if (en) begin
      bx_q    <= {{(CW-43){bprod[32]}}, bprod, 10'b0};
      ep_q    <= eprod[59:0];
      bx2_q   <= bx_a;
      term_q  <= bx2_q - {{(CW-48){ep_rnd[59]}}, ep_rnd[59:12]};
      cp_q    <= $signed({1'b0, shape_q}) * $signed(a2[33:0]);
      t_q     <= t_sum[36:0];
      r_q     <= m1[32:0];
      z0_q    <= fold;
      dp_q    <= $signed({1'b0, peak_q}) * sin_y;
      force_q <= f_sat;
    end
  end

  assign force_if_o.valid      = out_vld_q;
  assign force_if_o.tire_force = force_q;

  `TMFF_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> !force_if_o.valid, "force valid after reset")
  `TMFF_ASSERT(a_stall_freezes, (force_if_o.valid && !force_if_o.ready) |=> $stable(vld1_q) && $stable(vld8_q), "pipeline moved while output stalled")
  `TMFF_ASSERT(a_mod_range, vld6_q |-> ({4'b0, r_q} < TwoPiQ30), "sine argument not reduced below two pi")
  `TMFF_ASSERT(a_fold_range, vld7_q |-> (z0_q <= HalfPiS) && (z0_q >= -HalfPiS), "folded angle outside half pi")

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the magic formula tire force pipeline: slip beats
// go in under several coefficient settings and idle patterns, every force
// beat is checked against a fixed-point model of the formula kept here
// ----------------------------------------------------------------------------
module tb;
  import tmff_pkg::*;

  localparam int unsigned Stages   = CordicStagesDef;
  localparam int          Latency  = 3 * Stages + 9;
  localparam int          IdleLimit = 20000;

  // force predictor plus the list of forces still owed by the pipeline
  class force_scoreboard;
    logic [15:0] coef_b = StiffnessRst;
    logic [15:0] coef_c = ShapeRst;
    logic [15:0] coef_d = PeakRst;
    logic [15:0] coef_e = CurvatureRst;
    logic signed [16:0] owed_forces[$];
    int errors = 0;

    // round half up from s fraction bits
    function longint round_shift(longint v, int s);
      return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function longint cordic_arctan(longint v);
      longint x, y, z, xs, ys, step;
      x = OneQ30;
      y = v;
      z = 0;
      for (int i = 0; i < Stages; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        step = AtanTab[i];
        if (y >= 0) begin
          x = x + ys; y = y - xs; z = z + step;
        end else begin
          x = x - ys; y = y + xs; z = z - step;
        end
      end
      return z;
    endfunction

    function longint cordic_sine(longint a);
      longint r, x, y, z, xs, ys, step, pi, half_pi, two_pi;
      pi = PiQ30;
      half_pi = HalfPiQ30;
      two_pi = TwoPiQ30;
      // fold the angle into [-pi/2, pi/2]
      r = a % two_pi;
      if (r < 0) r += two_pi;
      if (r >= pi) r -= two_pi;
      if (r > half_pi) r = pi - r;
      else if (r < -half_pi) r = -pi - r;
      x = GainQ30;
      y = 0;
      z = r;
      for (int i = 0; i < Stages; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        step = AtanTab[i];
        if (z >= 0) begin
          x = x - ys; y = y + xs; z = z - step;
        end else begin
          x = x + ys; y = y - xs; z = z + step;
        end
      end
      return y;
    endfunction

    function logic signed [16:0] predict_force(logic signed [15:0] slip);
      longint bx, a1, term, a2, theta, f;
      bx = longint'(coef_b) * longint'(slip) * 1024;
      a1 = cordic_arctan(bx);
      term = bx - round_shift(longint'($signed(coef_e)) * (bx - a1), 12);
      a2 = cordic_arctan(term);
      theta = round_shift(longint'(coef_c) * a2, 12);
      f = round_shift(longint'(coef_d) * cordic_sine(theta), 30);
      if (f > 65535) f = 65535;
      if (f < -65536) f = -65536;
      return f[16:0];
    endfunction

    function void note_slip(logic signed [15:0] slip);
      owed_forces.push_back(predict_force(slip));
    endfunction

    function void check_force(logic signed [16:0] got);
      logic signed [16:0] want;
      if (owed_forces.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected force beat %0d", got);
        return;
      end
      want = owed_forces.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) $display("force mismatch: expected %0d, got %0d", want, got);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = RegStiffness;
  logic [15:0] cfg_data_i = '0;

  tmff_slip_if slip_ch ();
  tmff_force_if force_ch ();

  tire_magic_formula_force i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .slip_if_i  (slip_ch.sink),
    .force_if_o (force_ch.source)
  );

  always #2 clk_i = ~clk_i;

  force_scoreboard sb = new();

  // idle pattern: 0 none, 1 sender gaps, 2 receiver stalls, 3 both lightly
  int idle_mode = 0;
  int rx_hold = 0;
  int idle_cycles = 0;

  initial begin
    slip_ch.valid = 1'b0;
    slip_ch.slip_value = '0;
    force_ch.ready = 1'b0;
  end

  // receiver: random stalls, or a long hold-off while the sender keeps going
  always @(negedge clk_i) begin
    if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      force_ch.ready <= 1'b0;
    end else if (idle_mode == 2) begin
      force_ch.ready <= ($urandom_range(99, 0) >= 76);
    end else if (idle_mode == 3) begin
      force_ch.ready <= ($urandom_range(99, 0) >= 17);
    end else begin
      force_ch.ready <= 1'b1;
    end
  end

  // accepted beats on both channels, sampled at the rising edge
  always @(posedge clk_i) begin
    if (slip_ch.valid && slip_ch.ready) sb.note_slip(slip_ch.slip_value);
    if (force_ch.valid && force_ch.ready) sb.check_force(force_ch.tire_force);
  end

  // watchdog on cycles with no beat moving anywhere
  always @(posedge clk_i) begin
    if ((slip_ch.valid && slip_ch.ready) || (force_ch.valid && force_ch.ready)) begin
      idle_cycles <= 0;
    end else if (rst_ni) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // coefficient write, only with the pipeline drained
  task automatic write_coef(cfg_reg_e idx, logic [15:0] value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      RegStiffness: sb.coef_b = value;
      RegShape:     sb.coef_c = value;
      RegPeak:      sb.coef_d = value;
      default:      sb.coef_e = value;
    endcase
  endtask

  task automatic drain();
    while (sb.owed_forces.size() != 0) @(posedge clk_i);
    repeat (Latency + 10) @(posedge clk_i);
  endtask

  // one slip beat; called at a falling edge, returns at a falling edge
  task automatic send_slip(logic signed [15:0] slip);
    int idle_pct;
    idle_pct = (idle_mode == 1) ? 76 : (idle_mode == 3) ? 17 : 0;
    // each cycle the sender stays idle with the phase's probability
    while ($urandom_range(99, 0) < idle_pct) begin
      slip_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    slip_ch.valid <= 1'b1;
    slip_ch.slip_value <= slip;
    @(posedge clk_i);
    while (!slip_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic logic signed [15:0] random_slip();
    int r;
    r = $urandom_range(99, 0);
    // mostly the useful region around the force peak, sometimes anything
    if (r < 60) return 16'($signed($urandom_range(2400, 0)) - 1200);
    if (r < 80) return 16'($signed($urandom_range(16384, 0)) - 8192);
    return 16'($urandom());
  endfunction

  task automatic run_phase(int phase, int count);
    logic signed [15:0] corner[10] = '{16'sd0, 16'sd1, -16'sd1, 16'sd32767, -16'sd32768,
                                      16'sd410, -16'sd410, 16'sd4096, -16'sd4096, 16'sd205};
    idle_mode = phase % 4;
    @(negedge clk_i);
    foreach (corner[k]) send_slip(corner[k]);
    for (int n = 0; n < count; n++) begin
      // long receiver hold-off so the pipeline fills and backs up the input
      if (phase == 1 && n == 20) rx_hold = 300;
      // sender waits for every owed force before going on
      if (phase == 2 && n == 100) begin
        slip_ch.valid <= 1'b0;
        while (sb.owed_forces.size() != 0) @(negedge clk_i);
      end
      send_slip(random_slip());
    end
    slip_ch.valid <= 1'b0;
    drain();
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset coefficients
    run_phase(0, 190);
    // zero stiffness gives zero force
    write_coef(RegStiffness, 16'd0);
    run_phase(1, 190);
    // every coefficient at its top, curvature at its positive end
    write_coef(RegStiffness, 16'hFFFF);
    write_coef(RegShape, 16'hFFFF);
    write_coef(RegPeak, 16'hFFFF);
    write_coef(RegCurvature, 16'h7FFF);
    run_phase(2, 190);
    // most negative curvature and a large peak
    write_coef(RegStiffness, 16'd2560);
    write_coef(RegShape, 16'd12000);
    write_coef(RegPeak, 16'd60000);
    write_coef(RegCurvature, 16'h8000);
    run_phase(3, 190);
    // smallest nonzero stiffness, every other coefficient zero
    write_coef(RegStiffness, 16'd1);
    write_coef(RegShape, 16'd0);
    write_coef(RegPeak, 16'd0);
    write_coef(RegCurvature, 16'd0);
    run_phase(4, 150);
    // a few random settings
    for (int p = 5; p < 8; p++) begin
      write_coef(RegStiffness, 16'($urandom()));
      write_coef(RegShape, 16'($urandom()));
      write_coef(RegPeak, 16'($urandom()));
      write_coef(RegCurvature, 16'($urandom()));
      run_phase(p, 150);
    end

    if (sb.errors == 0 && sb.owed_forces.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

// File: tire_magic_formula_force.f
+incdir+rtl/core
rtl/core/tmff_pkg.sv
rtl/core/tmff_if.sv
rtl/core/tmff_cordic.sv
rtl/core/tire_magic_formula_force.sv
sim/tb.sv
